// ----- src/iewma_pkg.sv -----
// ----------------------------------------------------------------------------
// iewma_pkg
// shared constants, types and codes of the irregular ewma mean/std unit
// ----------------------------------------------------------------------------
package iewma_pkg;

	localparam int MAX_VALUES = 256;
	localparam int COL_W      = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
	localparam int N_W        = ($clog2(MAX_VALUES + 1) > 9) ? $clog2(MAX_VALUES + 1) : 9;

	// register file
	localparam int ADDR_W   = 3;
	localparam int RATE_W   = 32;
	localparam int COLS_W   = 9;
	localparam logic REG_DECAY_RATE = 1'b0;
	localparam logic REG_COLUMNS    = 1'b1;
	localparam logic [RATE_W-1:0] RATE_RESET = 32'hFFFF_FFFF;
	localparam logic [COLS_W-1:0] COLS_RESET = 9'd1;

	// fixed point constants
	localparam logic [31:0] LN2_Q31    = 32'd1488522236;
	localparam logic [31:0] ONE_Q31    = 32'h8000_0000;
	localparam logic [47:0] WEIGHT_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [47:0] WEIGHT_ONE = 48'h0000_0001_0000;
	localparam int          EXP_TERMS  = 12;

	// shared divide / square root unit
	localparam int NUM_W = 80;
	localparam int DEN_W = 48;
	localparam int REM_W = 49;
	localparam int CNT_W = 7;
	localparam logic [CNT_W-1:0] CNT_DIV_FULL = 7'd80;
	localparam logic [CNT_W-1:0] CNT_DIV_WORD = 7'd32;
	localparam logic [CNT_W-1:0] CNT_SQRT     = 7'd32;

	typedef enum logic {
		ITER_DIV,
		ITER_SQRT
	} iter_mode_t;

	typedef struct packed {
		logic             start;
		iter_mode_t       mode;
		logic [CNT_W-1:0] count;
	} iter_req_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_E_MUL,
		ST_E_Y,
		ST_E_T,
		ST_E_TM,
		ST_E_TD,
		ST_E_TW,
		ST_E_L,
		ST_W_HI,
		ST_W_LO,
		ST_W_ADD,
		ST_S_HI,
		ST_S_LO,
		ST_S_ADD,
		ST_M_DIV,
		ST_M_WAIT,
		ST_Q_HI,
		ST_Q_LO,
		ST_Q_XX,
		ST_Q_ADD,
		ST_V_DIV,
		ST_V_WAIT,
		ST_R_SQ,
		ST_R_WAIT
	} seq_state_t;

endpackage

// ----- src/iewma_in_if.sv -----
// ----------------------------------------------------------------------------
// iewma_in_if
// input channel: one sample or segment reset per transfer
// ----------------------------------------------------------------------------
interface iewma_in_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic [31:0]        lapse;
	logic signed [31:0] sample;

	modport source (output valid, func, lapse, sample, input ready);
	modport sink   (input valid, func, lapse, sample, output ready);
endinterface

// ----- src/iewma_out_if.sv -----
// ----------------------------------------------------------------------------
// iewma_out_if
// result channel: mean and standard deviation of one column per transfer
// ----------------------------------------------------------------------------
interface iewma_out_if;
	logic               valid;
	logic               ready;
	logic [7:0]         column;
	logic signed [31:0] mean;
	logic [31:0]        std_dev;
	logic               last_in_row;

	modport source (output valid, column, mean, std_dev, last_in_row, input ready);
	modport sink   (input valid, column, mean, std_dev, last_in_row, output ready);
endinterface

// ----- src/iewma_mul.sv -----
// ----------------------------------------------------------------------------
// iewma_mul
// shared 32x32 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module iewma_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] prod
);
	logic [63:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= 64'(a) * 64'(b);
	end

	assign prod = prod_q;
endmodule

// ----- src/iewma_iter.sv -----
// ----------------------------------------------------------------------------
// iewma_iter
// shared iterative unit: restoring divide or square root, one digit a cycle
// ----------------------------------------------------------------------------
module iewma_iter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  iewma_pkg::iter_req_t       req,
	input  logic [iewma_pkg::NUM_W-1:0] num,
	input  logic [iewma_pkg::DEN_W-1:0] den,
	output logic                       busy,
	output logic [iewma_pkg::NUM_W-1:0] quo
);
	logic [iewma_pkg::NUM_W-1:0] num_q;
	logic [iewma_pkg::DEN_W-1:0] den_q;
	logic [iewma_pkg::REM_W-1:0] rem_q;
	logic [iewma_pkg::NUM_W-1:0] quo_q;
	logic [iewma_pkg::CNT_W-1:0] cnt_q;
	iewma_pkg::iter_mode_t       mode_q;

	logic [iewma_pkg::REM_W-1:0] sh;
	logic [iewma_pkg::REM_W-1:0] trial;
	logic                        ge;

	always_comb begin
		if (mode_q == iewma_pkg::ITER_SQRT) begin
			sh    = {rem_q[iewma_pkg::REM_W-3:0], num_q[iewma_pkg::NUM_W-1 -: 2]};
			trial = {15'd0, quo_q[31:0], 2'b01};
		end else begin
			sh    = {rem_q[iewma_pkg::REM_W-2:0], num_q[iewma_pkg::NUM_W-1]};
			trial = {1'b0, den_q};
		end
		ge = (sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= req.count;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quo_q  <= '0;
			mode_q <= req.mode;
		end else if (busy) begin
			rem_q <= ge ? (sh - trial) : sh;
			quo_q <= {quo_q[iewma_pkg::NUM_W-2:0], ge};
			if (mode_q == iewma_pkg::ITER_SQRT) begin
				num_q <= {num_q[iewma_pkg::NUM_W-3:0], 2'b00};
			end else begin
				num_q <= {num_q[iewma_pkg::NUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = quo_q;
endmodule

// ----- src/iewma_mem.sv -----
// ----------------------------------------------------------------------------
// iewma_mem
// per-column weighted sum and squared deviation store with valid bits
// ----------------------------------------------------------------------------
module iewma_mem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clear,
	input  logic                        rd_en,
	input  logic [iewma_pkg::COL_W-1:0] rd_addr,
	output logic [127:0]                rd_data,
	input  logic                        wr_en,
	input  logic [iewma_pkg::COL_W-1:0] wr_addr,
	input  logic [127:0]                wr_data
);
	logic [127:0]                    mem [iewma_pkg::MAX_VALUES];
	logic [iewma_pkg::MAX_VALUES-1:0] valid_q;
	logic [127:0]                    rd_data_q;
	logic                            rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (clear) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// an entry not written since the last clear reads as zero
	assign rd_data = rd_valid_q ? rd_data_q : '0;
endmodule

// ----- src/irregular_ewma_mean_std_unit.sv -----
// ----------------------------------------------------------------------------
// irregular_ewma_mean_std_unit
// exponentially weighted moving mean and standard deviation over rows of
// samples taken at irregular times
// ----------------------------------------------------------------------------
// One item is taken at a time. For a sample that is not the first of its row,
// the shared divide / square root unit runs 80 steps for the mean, 80 for the
// variance and 32 for the square root, with the shared multiplier and the wait
// states around it. A row's first sample first works out the decay
// 2^-(lapse*rate), a twelve-term series with a multiply and a 32-step divide
// per term, unless the decay underflows to zero. A segment reset is taken in
// the idle state and clears the weight, the row position and all column sums
// at once. The result sits in an output register, so the next item may enter
// while a result still waits for its transfer. Configuration goes through the
// APB port: decay_rate at 0x0, columns_in_use at 0x4.
module irregular_ewma_mean_std_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	iewma_in_if.sink                      in_ch,
	iewma_out_if.source                   out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [iewma_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	// configuration registers
	logic [iewma_pkg::RATE_W-1:0] rate_q;
	logic [iewma_pkg::COLS_W-1:0] cols_q;

	// sequencer
	iewma_pkg::seq_state_t state_q, state_d;

	// segment state
	logic [47:0]                 weight_q;
	logic [31:0]                 decay_q;
	logic [iewma_pkg::COL_W-1:0] pos_q;

	// item and scratch registers
	logic [31:0]        lapse_q;
	logic signed [31:0] sample_q;
	logic [4:0]         k_q;
	logic [31:0]        y_q;
	logic [31:0]        t_q;
	logic signed [34:0] s_q;
	logic [3:0]         n_q;
	logic [63:0]        acc_q;
	logic [63:0]        sum_q;
	logic signed [31:0] mean_q;
	logic [63:0]        sqs_q;
	logic [63:0]        sq_q;
	logic [63:0]        var_q;

	// output register
	logic               out_valid_q;
	logic [7:0]         out_column_q;
	logic signed [31:0] out_mean_q;
	logic [31:0]        out_std_q;
	logic               out_last_q;

	// shared units
	logic [31:0]                 mul_a, mul_b;
	logic [63:0]                 prod;
	iewma_pkg::iter_req_t        iter_req;
	logic [iewma_pkg::NUM_W-1:0] iter_num;
	logic [iewma_pkg::DEN_W-1:0] iter_den;
	logic                        iter_busy;
	logic [iewma_pkg::NUM_W-1:0] iter_quo;

	// column store
	logic         mem_clear, mem_rd, mem_wr;
	logic [127:0] mem_rdata;

	logic in_xfer, out_xfer, cfg_wr, out_free;

	// --- configuration port ---------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= iewma_pkg::RATE_RESET;
			cols_q <= iewma_pkg::COLS_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				iewma_pkg::REG_DECAY_RATE: rate_q <= pwdata;
				iewma_pkg::REG_COLUMNS:    cols_q <= pwdata[iewma_pkg::COLS_W-1:0];
				default:                   rate_q <= rate_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			iewma_pkg::REG_DECAY_RATE: prdata = rate_q;
			iewma_pkg::REG_COLUMNS:    prdata = 32'(cols_q);
			default:                   prdata = '0;
		endcase
	end

	// --- handshakes -----------------------------------------------------------
	assign in_ch.ready = (state_q == iewma_pkg::ST_IDLE);
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign out_xfer    = out_valid_q && out_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	// --- derived values -------------------------------------------------------
	// effective row length, clamped to 1..MAX_VALUES
	logic [iewma_pkg::N_W-1:0] row_len;
	logic                      last_col;
	always_comb begin
		if (cols_q == '0) begin
			row_len = iewma_pkg::N_W'(1);
		end else if (32'(cols_q) > 32'(iewma_pkg::MAX_VALUES)) begin
			row_len = iewma_pkg::N_W'(iewma_pkg::MAX_VALUES);
		end else begin
			row_len = iewma_pkg::N_W'(cols_q);
		end
		last_col = (iewma_pkg::N_W'(pos_q) + 1'b1 >= row_len);
	end

	// stored sums of the current column
	logic [63:0] old_sum, old_sq, old_mag, scaled;
	logic        old_neg;
	assign old_sum = mem_rdata[127:64];
	assign old_sq  = mem_rdata[63:0];
	assign old_neg = old_sum[63];
	assign old_mag = old_neg ? (64'd0 - old_sum) : old_sum;
	// high partial product doubled plus low partial product over 2^31
	assign scaled  = acc_q + 64'(prod[63:31]);

	// saturating signed add of the sample to the decayed sum
	logic [63:0] sum_dec, v64, sum_add, sum_new;
	always_comb begin
		sum_dec = old_neg ? (64'd0 - scaled) : scaled;
		v64     = 64'(sample_q);
		sum_add = sum_dec + v64;
		if (sum_dec[63] == v64[63] && sum_add[63] != v64[63]) begin
			sum_new = v64[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		end else begin
			sum_new = sum_add;
		end
	end

	logic        sum_neg;
	logic [63:0] sum_mag;
	assign sum_neg = sum_q[63];
	assign sum_mag = sum_neg ? (64'd0 - sum_q) : sum_q;

	// mean from the quotient, clamped to the signed 32-bit range
	logic [31:0] mean_mag;
	logic [79:0] mean_cap;
	always_comb begin
		mean_cap = sum_neg ? 80'h8000_0000 : 80'h7FFF_FFFF;
		mean_mag = (iter_quo > mean_cap) ? mean_cap[31:0] : iter_quo[31:0];
	end

	// magnitude of the deviation, at most 2^32-1
	logic signed [32:0] dev;
	logic [31:0]        dev_mag;
	assign dev     = 33'(sample_q) - 33'(mean_q);
	assign dev_mag = dev[32] ? 32'(-dev) : dev[31:0];

	logic [64:0] sq_sum;
	assign sq_sum = {1'b0, sqs_q} + {1'b0, prod};

	logic [64:0] w_sum;
	assign w_sum = {1'b0, scaled} + 65'(iewma_pkg::WEIGHT_ONE);

	// decay series term update and final clamp
	logic signed [34:0] s_next;
	logic [31:0]        s_clamp;
	always_comb begin
		s_next = n_q[0] ? (s_q - 35'(iter_quo[31:0])) : (s_q + 35'(iter_quo[31:0]));
		if (s_q < 0) begin
			s_clamp = '0;
		end else if (s_q > 35'(iewma_pkg::ONE_Q31)) begin
			s_clamp = iewma_pkg::ONE_Q31;
		end else begin
			s_clamp = s_q[31:0];
		end
	end

	logic [47:0] weight_div;
	assign weight_div = (weight_q == '0) ? 48'd1 : weight_q;

	// --- sequencer: next state ------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			iewma_pkg::ST_IDLE: begin
				if (in_xfer && !in_ch.func) begin
					state_d = (pos_q == '0) ? iewma_pkg::ST_E_MUL : iewma_pkg::ST_S_HI;
				end
			end
			iewma_pkg::ST_E_MUL: state_d = iewma_pkg::ST_E_Y;
			iewma_pkg::ST_E_Y: begin
				state_d = (|prod[63:45]) ? iewma_pkg::ST_W_HI : iewma_pkg::ST_E_T;
			end
			iewma_pkg::ST_E_T:  state_d = iewma_pkg::ST_E_TM;
			iewma_pkg::ST_E_TM: state_d = iewma_pkg::ST_E_TD;
			iewma_pkg::ST_E_TD: state_d = iewma_pkg::ST_E_TW;
			iewma_pkg::ST_E_TW: begin
				if (!iter_busy) begin
					state_d = (n_q == 4'(iewma_pkg::EXP_TERMS)) ?
						iewma_pkg::ST_E_L : iewma_pkg::ST_E_TM;
				end
			end
			iewma_pkg::ST_E_L:   state_d = iewma_pkg::ST_W_HI;
			iewma_pkg::ST_W_HI:  state_d = iewma_pkg::ST_W_LO;
			iewma_pkg::ST_W_LO:  state_d = iewma_pkg::ST_W_ADD;
			iewma_pkg::ST_W_ADD: state_d = iewma_pkg::ST_S_HI;
			iewma_pkg::ST_S_HI:  state_d = iewma_pkg::ST_S_LO;
			iewma_pkg::ST_S_LO:  state_d = iewma_pkg::ST_S_ADD;
			iewma_pkg::ST_S_ADD: state_d = iewma_pkg::ST_M_DIV;
			iewma_pkg::ST_M_DIV: state_d = iewma_pkg::ST_M_WAIT;
			iewma_pkg::ST_M_WAIT: begin
				if (!iter_busy) begin
					state_d = iewma_pkg::ST_Q_HI;
				end
			end
			iewma_pkg::ST_Q_HI:  state_d = iewma_pkg::ST_Q_LO;
			iewma_pkg::ST_Q_LO:  state_d = iewma_pkg::ST_Q_XX;
			iewma_pkg::ST_Q_XX:  state_d = iewma_pkg::ST_Q_ADD;
			iewma_pkg::ST_Q_ADD: state_d = iewma_pkg::ST_V_DIV;
			iewma_pkg::ST_V_DIV: state_d = iewma_pkg::ST_V_WAIT;
			iewma_pkg::ST_V_WAIT: begin
				if (!iter_busy) begin
					state_d = iewma_pkg::ST_R_SQ;
				end
			end
			iewma_pkg::ST_R_SQ: state_d = iewma_pkg::ST_R_WAIT;
			iewma_pkg::ST_R_WAIT: begin
				if (!iter_busy && out_free) begin
					state_d = iewma_pkg::ST_IDLE;
				end
			end
			default: state_d = iewma_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iewma_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// --- sequencer: unit controls ---------------------------------------------
	always_comb begin
		mul_a          = '0;
		mul_b          = decay_q;
		iter_req.start = 1'b0;
		iter_req.mode  = iewma_pkg::ITER_DIV;
		iter_req.count = iewma_pkg::CNT_DIV_FULL;
		iter_num       = {sum_mag, 16'd0};
		iter_den       = weight_div;
		mem_rd         = 1'b0;
		mem_wr         = 1'b0;
		mem_clear      = 1'b0;
		case (state_q)
			iewma_pkg::ST_IDLE: begin
				mem_rd    = in_xfer && !in_ch.func;
				mem_clear = in_xfer && in_ch.func;
			end
			iewma_pkg::ST_E_MUL: begin
				mul_a = lapse_q;
				mul_b = rate_q;
			end
			iewma_pkg::ST_E_Y: begin
				mul_a = {1'b0, prod[39:9]};
				mul_b = iewma_pkg::LN2_Q31;
			end
			iewma_pkg::ST_E_TM: begin
				mul_a = t_q;
				mul_b = y_q;
			end
			iewma_pkg::ST_E_TD: begin
				iter_req.start = 1'b1;
				iter_req.count = iewma_pkg::CNT_DIV_WORD;
				iter_num       = {prod[62:31], 48'd0};
				iter_den       = 48'(n_q);
			end
			iewma_pkg::ST_W_HI: mul_a = {16'd0, weight_q[47:32]};
			iewma_pkg::ST_W_LO: mul_a = weight_q[31:0];
			iewma_pkg::ST_S_HI: mul_a = old_mag[63:32];
			iewma_pkg::ST_S_LO: mul_a = old_mag[31:0];
			iewma_pkg::ST_M_DIV: iter_req.start = 1'b1;
			iewma_pkg::ST_Q_HI:  mul_a = old_sq[63:32];
			iewma_pkg::ST_Q_LO:  mul_a = old_sq[31:0];
			iewma_pkg::ST_Q_XX: begin
				mul_a = dev_mag;
				mul_b = dev_mag;
			end
			iewma_pkg::ST_V_DIV: begin
				// sum and squared deviation are both settled here
				mem_wr         = 1'b1;
				iter_req.start = 1'b1;
				iter_num       = {sq_q, 16'd0};
			end
			iewma_pkg::ST_R_SQ: begin
				iter_req.start = 1'b1;
				iter_req.mode  = iewma_pkg::ITER_SQRT;
				iter_req.count = iewma_pkg::CNT_SQRT;
				iter_num       = {var_q, 16'd0};
			end
			default: mul_a = '0;
		endcase
	end

	// --- segment state --------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= '0;
			decay_q  <= '0;
			pos_q    <= '0;
		end else if (mem_clear) begin
			weight_q <= '0;
			decay_q  <= '0;
			pos_q    <= '0;
		end else begin
			case (state_q)
				iewma_pkg::ST_E_Y: begin
					// decay underflows to zero for 32 or more halvings
					if (|prod[63:45]) begin
						decay_q <= '0;
					end
				end
				iewma_pkg::ST_E_L: decay_q <= s_clamp >> k_q;
				iewma_pkg::ST_W_ADD: begin
					weight_q <= (w_sum > 65'(iewma_pkg::WEIGHT_MAX)) ?
						iewma_pkg::WEIGHT_MAX : w_sum[47:0];
				end
				iewma_pkg::ST_R_WAIT: begin
					if (!iter_busy && out_free) begin
						pos_q <= last_col ? '0 : pos_q + 1'b1;
					end
				end
				default: pos_q <= pos_q;
			endcase
		end
	end

	// --- datapath scratch -----------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			iewma_pkg::ST_IDLE: begin
				if (in_xfer) begin
					lapse_q  <= in_ch.lapse;
					sample_q <= in_ch.sample;
				end
			end
			iewma_pkg::ST_E_Y: k_q <= prod[44:40];
			iewma_pkg::ST_E_T: begin
				y_q <= 32'(prod[63:31]);
				t_q <= iewma_pkg::ONE_Q31;
				s_q <= 35'(iewma_pkg::ONE_Q31);
				n_q <= 4'd1;
			end
			iewma_pkg::ST_E_TW: begin
				if (!iter_busy) begin
					t_q <= iter_quo[31:0];
					s_q <= s_next;
					n_q <= n_q + 1'b1;
				end
			end
			iewma_pkg::ST_W_LO:  acc_q <= {prod[62:0], 1'b0};
			iewma_pkg::ST_S_LO:  acc_q <= {prod[62:0], 1'b0};
			iewma_pkg::ST_S_ADD: sum_q <= sum_new;
			iewma_pkg::ST_M_WAIT: begin
				if (!iter_busy) begin
					mean_q <= sum_neg ? (32'sd0 - $signed(mean_mag)) : $signed(mean_mag);
				end
			end
			iewma_pkg::ST_Q_LO:  acc_q <= {prod[62:0], 1'b0};
			iewma_pkg::ST_Q_XX:  sqs_q <= scaled;
			iewma_pkg::ST_Q_ADD: sq_q <= sq_sum[64] ? '1 : sq_sum[63:0];
			iewma_pkg::ST_V_WAIT: begin
				if (!iter_busy) begin
					var_q <= (|iter_quo[79:64]) ? '1 : iter_quo[63:0];
				end
			end
			default: acc_q <= acc_q;
		endcase
	end

	// --- output register ------------------------------------------------------
	logic out_load;
	assign out_load = (state_q == iewma_pkg::ST_R_WAIT) && !iter_busy && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_column_q <= 8'(pos_q);
			out_mean_q   <= mean_q;
			out_std_q    <= iter_quo[31:0];
			out_last_q   <= last_col;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.column      = out_column_q;
	assign out_ch.mean        = out_mean_q;
	assign out_ch.std_dev     = out_std_q;
	assign out_ch.last_in_row = out_last_q;

	// --- shared units and store -----------------------------------------------
	iewma_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	iewma_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (iter_req),
		.num    (iter_num),
		.den    (iter_den),
		.busy   (iter_busy),
		.quo    (iter_quo)
	);

	iewma_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (mem_clear),
		.rd_en   (mem_rd),
		.rd_addr (pos_q),
		.rd_data (mem_rdata),
		.wr_en   (mem_wr),
		.wr_addr (pos_q),
		.wr_data ({sum_q, sq_q})
	);

`ifndef SYNTHESIS
	// a sample transfer starts the sequencer
	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !in_ch.func) |=> (state_q != iewma_pkg::ST_IDLE))
		else $error("sample transfer did not start the sequencer");

	// a segment reset leaves zero weight and row position
	a_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && in_ch.func) |=> (weight_q == '0 && pos_q == '0))
		else $error("segment reset did not clear the state");

	// the shared unit is never restarted while still working
	a_iter_free: assert property (@(posedge clk) disable iff (!arst_n)
		iter_req.start |-> !iter_busy)
		else $error("iterative unit started while busy");

	// decay never exceeds one
	a_decay_range: assert property (@(posedge clk) disable iff (!arst_n)
		decay_q <= iewma_pkg::ONE_Q31)
		else $error("decay factor above one");

	// a result is loaded only into a free output register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result overwrote a pending transfer");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the irregular ewma mean/std unit: rows of samples
// and segment resets go in through a randomly idling sender, results come back
// through a randomly stalling receiver, and every result is compared field by
// field with a bit-exact fixed-point model of the running mean and deviation
// ----------------------------------------------------------------------------
module tb_top;

	localparam int  CLK_HALF   = 10;
	localparam int  DRAIN_WAIT = 800;       // wait after the queues empty, covers a row start
	localparam int  HOLD_LEN   = 4000;      // long receiver hold-off
	localparam longint CYCLE_LIMIT = 12000000;
	localparam bit [63:0] SGN_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam bit [63:0] SGN_MIN = 64'h8000_0000_0000_0000;

	typedef enum bit {FN_SAMPLE = 1'b0, FN_SEG_RESET = 1'b1} func_t;

	typedef struct {
		func_t       func;
		bit [31:0]   lapse;
		bit [31:0]   sample;
	} sample_item_t;

	typedef struct {
		bit [7:0]    column;
		bit [31:0]   mean;
		bit [31:0]   std_dev;
		bit          last_in_row;
	} col_stat_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [iewma_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;

	iewma_in_if  in_ch ();
	iewma_out_if out_ch ();

	irregular_ewma_mean_std_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// clock
	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// stimulus and expectation stores
	sample_item_t pending_items[$];
	col_stat_t    expected_stats[$];

	int src_idle_pct = 21;
	int snk_idle_pct = 73;
	bit hold_toggle  = 1'b0;
	int mismatches   = 0;
	int results_seen = 0;
	int samples_in   = 0;
	int resets_in    = 0;
	int rows_closed  = 0;

	// model copy of configuration and state
	bit [31:0] cfg_rate;
	bit [8:0]  cfg_cols;
	bit [47:0] wt;
	bit [31:0] row_decay;
	int        col_pos;
	bit [63:0] col_sum [iewma_pkg::MAX_VALUES];   // signed contents
	bit [63:0] col_sq  [iewma_pkg::MAX_VALUES];

	// ------------------------------------------------------------------
	// fixed-point model
	// ------------------------------------------------------------------
	function automatic bit [31:0] decay_of(bit [31:0] lapse, bit [31:0] rate);
		bit [63:0] e, f, y, t;
		longint    s;
		int        k;
		e = 64'(lapse) * 64'(rate);
		if ((e >> 40) >= 32)
			return 32'd0;
		k = int'(e >> 40);
		f = (e >> 9) & 64'h7FFF_FFFF;
		y = (f * 64'(iewma_pkg::LN2_Q31)) >> 31;
		t = 64'h8000_0000;
		s = 64'h8000_0000;
		for (int n = 1; n <= iewma_pkg::EXP_TERMS; n++) begin
			t = ((t * y) >> 31) / n;
			if (n % 2 == 1)
				s = s - longint'(t);
			else
				s = s + longint'(t);
		end
		if (s < 0)
			s = 0;
		if (s > 64'h8000_0000)
			s = 64'h8000_0000;
		return 32'(s >> k);
	endfunction

	function automatic bit [63:0] scale_mag(bit [63:0] x, bit [31:0] l);
		bit [63:0] hi, lo;
		hi = x >> 32;
		lo = x & 64'hFFFF_FFFF;
		return ((hi * 64'(l)) << 1) + ((lo * 64'(l)) >> 31);
	endfunction

	// magnitude scaled, sign put back: truncation toward zero
	function automatic bit [63:0] scale_signed(bit [63:0] x, bit [31:0] l);
		bit [63:0] m;
		if (!x[63])
			return scale_mag(x, l);
		m = scale_mag(64'd0 - x, l);
		if (m > SGN_MAX)
			return SGN_MIN;
		return 64'd0 - m;
	endfunction

	function automatic bit [63:0] add_signed_sat(bit [63:0] a, bit [63:0] b);
		bit [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? SGN_MIN : SGN_MAX;
		return s[63:0];
	endfunction

	// floor(x * 2^16 / d), saturating at cap
	function automatic bit [63:0] div_frac(bit [63:0] x, bit [63:0] d, bit [63:0] cap);
		bit [63:0] q, r, v;
		if (d == 0)
			d = 1;
		q = x / d;
		r = x % d;
		if (q >= 64'h0001_0000_0000_0000)
			return cap;
		v = (q << 16) + ((r << 16) / d);
		return (v > cap) ? cap : v;
	endfunction

	function automatic bit [63:0] root64(bit [63:0] v);
		bit [63:0] r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic void clear_segment();
		wt = 0;
		row_decay = 0;
		col_pos = 0;
		for (int i = 0; i < iewma_pkg::MAX_VALUES; i++) begin
			col_sum[i] = 0;
			col_sq[i]  = 0;
		end
	endfunction

	// advance the model by one accepted item, queue the stats it produces
	function automatic void ewma_update(sample_item_t it);
		int        n, c;
		bit [63:0] v, mean, mag, x, xm, sq, var_q;
		bit [64:0] wide, w;
		bit        neg, last;
		col_stat_t st;
		if (it.func == FN_SEG_RESET) begin
			clear_segment();
			return;
		end
		n = cfg_cols;
		if (n < 1)
			n = 1;
		if (n > iewma_pkg::MAX_VALUES)
			n = iewma_pkg::MAX_VALUES;
		if (col_pos == 0) begin
			row_decay = decay_of(it.lapse, cfg_rate);
			w = 65'(scale_mag(64'(wt), row_decay)) + 65'(iewma_pkg::WEIGHT_ONE);
			wt = (w > 65'(iewma_pkg::WEIGHT_MAX)) ? iewma_pkg::WEIGHT_MAX : w[47:0];
		end
		c = col_pos % iewma_pkg::MAX_VALUES;
		v = {{32{it.sample[31]}}, it.sample};
		col_sum[c] = add_signed_sat(scale_signed(col_sum[c], row_decay), v);
		neg = col_sum[c][63];
		mag = neg ? 64'd0 - col_sum[c] : col_sum[c];
		mag = div_frac(mag, 64'(wt), neg ? 64'h8000_0000 : 64'h7FFF_FFFF);
		mean = neg ? 64'd0 - mag : mag;
		x = v - mean;
		xm = x[63] ? 64'd0 - x : x;
		xm = xm * xm;
		sq = scale_mag(col_sq[c], row_decay);
		wide = 65'(sq) + 65'(xm);
		sq = wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : wide[63:0];
		col_sq[c] = sq;
		var_q = div_frac(sq, 64'(wt), 64'hFFFF_FFFF_FFFF_FFFF);
		last = (col_pos + 1 >= n);
		st.column      = 8'(c);
		st.mean        = mean[31:0];
		st.std_dev     = root64(var_q) & 64'hFFFF_FFFF;
		st.last_in_row = last;
		expected_stats.push_back(st);
		col_pos = last ? 0 : col_pos + 1;
	endfunction

	// ------------------------------------------------------------------
	// driver: offers the head of the pending queue, updates the model on transfer
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				ewma_update(pending_items[0]);
				if (pending_items[0].func == FN_SEG_RESET)
					resets_in++;
				else
					samples_in++;
				pending_items.pop_front();
			end
			// an offered item stays put until it is taken
			if (!(in_ch.valid && !in_ch.ready)) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
					in_ch.valid  <= 1'b1;
					in_ch.func   <= pending_items[0].func;
					in_ch.lapse  <= pending_items[0].lapse;
					in_ch.sample <= pending_items[0].sample;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: random ready, long hold-off on request, compares each transfer
	// ------------------------------------------------------------------
	bit hold_seen = 1'b0;
	int hold_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (expected_stats.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result col=%0d mean=%h std=%h last=%b", $time,
						out_ch.column, out_ch.mean, out_ch.std_dev, out_ch.last_in_row);
				end else begin
					if (out_ch.column !== expected_stats[0].column ||
					    out_ch.mean !== expected_stats[0].mean ||
					    out_ch.std_dev !== expected_stats[0].std_dev ||
					    out_ch.last_in_row !== expected_stats[0].last_in_row) begin
						mismatches++;
						$display("%0t: expected col=%0d mean=%h std=%h last=%b", $time,
							expected_stats[0].column, expected_stats[0].mean,
							expected_stats[0].std_dev, expected_stats[0].last_in_row);
						$display("%0t:   actual col=%0d mean=%h std=%h last=%b", $time,
							out_ch.column, out_ch.mean, out_ch.std_dev,
							out_ch.last_in_row);
					end
					if (expected_stats[0].last_in_row)
						rows_closed++;
					expected_stats.pop_front();
				end
			end
			// hold-off: counted here, kicked by a toggle from the sequence
			if (hold_toggle != hold_seen) begin
				hold_seen <= hold_toggle;
				hold_left <= HOLD_LEN;
				out_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// run limit
	longint cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	task automatic reg_write(input bit idx, input bit [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= iewma_pkg::ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);   // write lands here, pready is always high
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == iewma_pkg::REG_DECAY_RATE)
			cfg_rate = value;
		else
			cfg_cols = value[8:0];
	endtask

	// wait until everything sent has come back, then let a row start finish
	task automatic drain();
		wait (pending_items.size() == 0 && expected_stats.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic push_item(func_t fn, bit [31:0] lapse, bit [31:0] sample);
		sample_item_t it;
		it.func   = fn;
		it.lapse  = lapse;
		it.sample = sample;
		pending_items.push_back(it);
	endtask

	// mostly well-formed rows with random content, a few segment resets
	task automatic push_random(int count);
		bit [31:0] lapse, sample;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 3) begin
				push_item(FN_SEG_RESET, $urandom, $urandom);
			end else begin
				case ($urandom_range(3))
					0: lapse = $urandom;
					1: lapse = $urandom_range(32'h0003_0000);
					2: lapse = $urandom_range(32'h0000_0400);
					default: lapse = 32'd0;
				endcase
				case ($urandom_range(3))
					0: sample = $urandom;
					1: sample = 32'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
					2: sample = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
					default: sample = 32'($signed($urandom_range(32'h0000_2000)));
				endcase
				push_item(FN_SAMPLE, lapse, sample);
			end
		end
	endtask

	bit [31:0] rate_set [10];
	bit [8:0]  cols_set [10];
	int        count_set[10];

	initial begin
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		cfg_rate = iewma_pkg::RATE_RESET;
		cfg_cols = iewma_pkg::COLS_RESET;
		clear_segment();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes under reset settings (near-zero memory)
		push_item(FN_SAMPLE, 32'd0, 32'h7FFF_FFFF);
		push_item(FN_SAMPLE, 32'hFFFF_FFFF, 32'h8000_0000);
		push_item(FN_SAMPLE, 32'd0, 32'h8000_0000);
		push_item(FN_SAMPLE, 32'h0000_0001, 32'h0000_0000);
		push_item(FN_SEG_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(FN_SAMPLE, 32'h0001_0000, 32'hFFFF_FFFF);
		drain();

		// no decay at all, and a segment reset mid-row
		reg_write(iewma_pkg::REG_DECAY_RATE, 32'd0);
		reg_write(iewma_pkg::REG_COLUMNS, 9'd3);
		push_item(FN_SAMPLE, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		push_item(FN_SAMPLE, 32'd0, 32'h7FFF_FFFF);
		push_item(FN_SAMPLE, 32'd0, 32'h8000_0000);
		push_item(FN_SAMPLE, 32'd0, 32'h7FFF_FFFF);
		push_item(FN_SEG_RESET, 32'd0, 32'd0);
		push_item(FN_SAMPLE, 32'h0000_8000, 32'h0001_0000);
		push_item(FN_SAMPLE, 32'd0, 32'hFFFF_0000);
		drain();

		// row length cut mid-row: position beyond the new length closes the row
		reg_write(iewma_pkg::REG_COLUMNS, 9'd1);
		push_item(FN_SAMPLE, 32'd0, 32'h0002_0000);
		drain();

		// column count zero acts as one; one second at rate 1.0 halves the memory
		reg_write(iewma_pkg::REG_COLUMNS, 9'd0);
		reg_write(iewma_pkg::REG_DECAY_RATE, 32'h0100_0000);
		push_item(FN_SAMPLE, 32'h0001_0000, 32'h0003_0000);
		push_item(FN_SAMPLE, 32'h0001_0000, 32'h0001_0000);
		push_item(FN_SAMPLE, 32'h001F_FFFF, 32'h0001_0000);
		push_item(FN_SAMPLE, 32'h0020_0000, 32'h0001_0000);
		drain();

		// random phases: several settings, extremes among them
		rate_set = '{32'h0100_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0040_0000, $urandom,
		             32'h0001_0000, 32'h0100_0000, $urandom_range(32'h0400_0000), 32'h0000_0100,
		             32'h0200_0000};
		cols_set = '{9'd4, 9'd1, 9'd3, 9'd511, 9'd2, 9'd0, 9'd8, 9'd5, 9'd256, 9'd7};
		count_set = '{160, 140, 160, 300, 150, 140, 160, 150, 270, 140};
		for (int p = 0; p < 10; p++) begin
			if (p < 4) begin
				src_idle_pct = 21;
				snk_idle_pct = 73;
			end else if (p < 7) begin
				src_idle_pct = 73;
				snk_idle_pct = 21;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			reg_write(iewma_pkg::REG_DECAY_RATE, rate_set[p]);
			reg_write(iewma_pkg::REG_COLUMNS, cols_set[p]);
			push_random(count_set[p]);
			// receiver stops for a long stretch while the sender keeps offering
			if (p == 2 || p == 7)
				hold_toggle = ~hold_toggle;
			drain();
		end

		$display("covered %0d samples and %0d segment resets, %0d results in %0d rows",
			samples_in, resets_in, results_seen, rows_closed);
		$display("settings: decay rate 0 to max, column counts 0 to 511, %0d cycles", cycles);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
